// ----- rtl/co2fx_pkg.sv -----
// ----------------------------------------------------------------------------
// CO2 sensor frame exchange package
// Shared opcodes, status codes, register indexes and the read command table.
// ----------------------------------------------------------------------------
`default_nettype none

package co2fx_pkg;

  // Request opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Reading status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LENGTH   = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_HEADER   = 3'd4;

  // Result kinds
  localparam logic KIND_CMD     = 1'b0;
  localparam logic KIND_READING = 1'b1;

  // Configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAX_PPM = 1'b1;

  localparam logic [23:0] TIMEOUT_RESET = 24'd8000000;
  localparam logic [15:0] MAX_PPM_RESET = 16'd5000;
  localparam logic [23:0] TICK_MAX      = 24'hFFFFFF;

  // Frame layout
  localparam logic [3:0] CMD_LAST_BEAT  = 4'd8;
  localparam logic [3:0] REPLY_LAST_IDX = 4'd8;
  localparam logic [3:0] IDX_HEADER0    = 4'd0;
  localparam logic [3:0] IDX_HEADER1    = 4'd1;
  localparam logic [3:0] IDX_PPM_HI     = 4'd2;
  localparam logic [3:0] IDX_PPM_LO     = 4'd3;
  localparam logic [7:0] HDR_START      = 8'hFF;
  localparam logic [7:0] HDR_READ       = 8'h86;

  // One pending result: a command burst or a finished reading
  typedef struct packed {
    logic        is_cmd;
    logic [2:0]  status;
    logic [15:0] ppm;
  } desc_t;

  // Read command FF 01 86 00 00 00 00 00 79
  function automatic logic [7:0] cmd_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hFF;
      4'd1:    b = 8'h01;
      4'd2:    b = 8'h86;
      4'd8:    b = 8'h79;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/co2fx_core.sv -----
// ----------------------------------------------------------------------------
// CO2 exchange core
// Tracks the reply frame, runs the timeout and loads one result descriptor.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fx_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           op,
  input  wire logic [7:0]           rx_byte,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [23:0]          cfg_data,
  output logic                      desc_valid,
  output co2fx_pkg::desc_t          desc,
  input  wire logic                 desc_take
);

  logic [23:0] timeout_ticks;
  logic [15:0] max_ppm;

  logic        waiting, waiting_next;
  logic [3:0]  bytes_seen, bytes_seen_next;
  logic [7:0]  byte_sum, byte_sum_next;
  logic        first_is_ff, first_is_ff_next;
  logic        second_is_86, second_is_86_next;
  logic [15:0] reading, reading_next;
  logic [23:0] tick_count, tick_count_next;

  logic              accept;
  logic              has_res;
  co2fx_pkg::desc_t  res;
  logic [23:0]       tick_inc;

  assign in_ready = !desc_valid || desc_take;
  assign accept   = in_valid && in_ready;
  assign tick_inc = (tick_count != co2fx_pkg::TICK_MAX) ? tick_count + 24'd1 : tick_count;

  always_comb begin
    waiting_next      = waiting;
    bytes_seen_next   = bytes_seen;
    byte_sum_next     = byte_sum;
    first_is_ff_next  = first_is_ff;
    second_is_86_next = second_is_86;
    reading_next      = reading;
    tick_count_next   = tick_count;
    has_res           = 1'b0;
    res.is_cmd        = 1'b0;
    res.status        = co2fx_pkg::ST_OK;
    res.ppm           = 16'd0;
    case (op)
      co2fx_pkg::OP_START: begin
        waiting_next      = 1'b1;
        bytes_seen_next   = 4'd0;
        byte_sum_next     = 8'd0;
        first_is_ff_next  = 1'b0;
        second_is_86_next = 1'b0;
        reading_next      = 16'd0;
        tick_count_next   = 24'd0;
        has_res           = 1'b1;
        res.is_cmd        = 1'b1;
      end
      co2fx_pkg::OP_BYTE: begin
        if (waiting && bytes_seen != co2fx_pkg::REPLY_LAST_IDX) begin
          bytes_seen_next = bytes_seen + 4'd1;
          if (bytes_seen == co2fx_pkg::IDX_HEADER0) begin
            first_is_ff_next = (rx_byte == co2fx_pkg::HDR_START);
          end else begin
            byte_sum_next = byte_sum + rx_byte;
          end
          if (bytes_seen == co2fx_pkg::IDX_HEADER1) begin
            second_is_86_next = (rx_byte == co2fx_pkg::HDR_READ);
          end
          if (bytes_seen == co2fx_pkg::IDX_PPM_HI) begin
            reading_next = {rx_byte, reading[7:0]};
          end
          if (bytes_seen == co2fx_pkg::IDX_PPM_LO) begin
            reading_next = {reading[15:8], rx_byte};
          end
        end else if (waiting) begin
          // Checksum byte: sum plus checksum wraps to zero when valid
          has_res = 1'b1;
          if (8'(byte_sum + rx_byte) != 8'd0) begin
            res.status = co2fx_pkg::ST_CHECKSUM;
          end else if (!(first_is_ff && second_is_86)) begin
            res.status = co2fx_pkg::ST_HEADER;
          end else if (reading > max_ppm) begin
            res.status = co2fx_pkg::ST_RANGE;
          end else begin
            res.status = co2fx_pkg::ST_OK;
            res.ppm    = reading;
          end
          waiting_next      = 1'b0;
          bytes_seen_next   = 4'd0;
          byte_sum_next     = 8'd0;
          first_is_ff_next  = 1'b0;
          second_is_86_next = 1'b0;
          reading_next      = 16'd0;
          tick_count_next   = 24'd0;
        end
      end
      co2fx_pkg::OP_TICK: begin
        if (waiting) begin
          if (tick_inc >= timeout_ticks) begin
            has_res           = 1'b1;
            res.status        = co2fx_pkg::ST_LENGTH;
            waiting_next      = 1'b0;
            bytes_seen_next   = 4'd0;
            byte_sum_next     = 8'd0;
            first_is_ff_next  = 1'b0;
            second_is_86_next = 1'b0;
            reading_next      = 16'd0;
            tick_count_next   = 24'd0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= co2fx_pkg::TIMEOUT_RESET;
      max_ppm       <= co2fx_pkg::MAX_PPM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == co2fx_pkg::REG_TIMEOUT) begin
        timeout_ticks <= cfg_data;
      end else begin
        max_ppm <= cfg_data[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting      <= 1'b0;
      bytes_seen   <= 4'd0;
      byte_sum     <= 8'd0;
      first_is_ff  <= 1'b0;
      second_is_86 <= 1'b0;
      reading      <= 16'd0;
      tick_count   <= 24'd0;
      desc_valid   <= 1'b0;
    end else begin
      if (accept) begin
        waiting      <= waiting_next;
        bytes_seen   <= bytes_seen_next;
        byte_sum     <= byte_sum_next;
        first_is_ff  <= first_is_ff_next;
        second_is_86 <= second_is_86_next;
        reading      <= reading_next;
        tick_count   <= tick_count_next;
      end
      if (accept && has_res) begin
        desc_valid <= 1'b1;
      end else if (desc_take) begin
        desc_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      desc <= res;
    end
  end

  a_bytes_bounded: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= co2fx_pkg::REPLY_LAST_IDX)
    else $error("reply byte count past frame end");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !waiting |-> (bytes_seen == 4'd0 && tick_count == 24'd0))
    else $error("idle with stale exchange state");

  a_desc_hold: assert property (@(posedge clk) disable iff (rst)
    desc_valid && !desc_take |=> desc_valid && $stable(desc))
    else $error("pending descriptor lost or changed");

endmodule

`default_nettype wire

// ----- rtl/co2fx_seq.sv -----
// ----------------------------------------------------------------------------
// CO2 exchange result sequencer
// Expands a descriptor into output beats: nine command bytes or one reading.
// ----------------------------------------------------------------------------
`default_nettype none

module co2fx_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 desc_valid,
  input  wire co2fx_pkg::desc_t     desc,
  output logic                      desc_take,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      kind,
  output logic [7:0]                tx_byte,
  output logic [2:0]                status,
  output logic [15:0]               ppm,
  output logic                      last
);

  logic             busy;
  logic [3:0]       beat;
  co2fx_pkg::desc_t cur;

  assign out_valid = busy;
  assign kind      = cur.is_cmd ? co2fx_pkg::KIND_CMD : co2fx_pkg::KIND_READING;
  assign tx_byte   = cur.is_cmd ? co2fx_pkg::cmd_byte(beat) : 8'd0;
  assign status    = cur.status;
  assign ppm       = cur.ppm;
  assign last      = !cur.is_cmd || (beat == co2fx_pkg::CMD_LAST_BEAT);
  assign desc_take = desc_valid && (!busy || (out_ready && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= 4'd0;
    end else if (desc_take) begin
      busy <= 1'b1;
      beat <= 4'd0;
    end else if (busy && out_ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        beat <= beat + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_take) begin
      cur <= desc;
    end
  end

  a_beat_bounded: assert property (@(posedge clk) disable iff (rst)
    busy |-> beat <= co2fx_pkg::CMD_LAST_BEAT)
    else $error("command beat past end");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    busy && out_ready && !last |=> busy && beat == $past(beat) + 4'd1)
    else $error("command burst broken");

  a_take_only_free: assert property (@(posedge clk) disable iff (rst)
    desc_take && busy |-> out_ready && last)
    else $error("descriptor taken over a live result");

endmodule

`default_nettype wire

// ----- rtl/co2_sensor_frame_exchange_unit.sv -----
// ----------------------------------------------------------------------------
// CO2 sensor frame exchange unit
// Drives one read exchange with a CO2 sensor: command bytes out, reply check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, op, rx_byte) carries requests: start,
//   one received byte, or one timer tick. Output channel (out_valid/out_ready)
//   carries results: a start yields the nine command bytes FF 01 86 00 00 00
//   00 00 79 (kind 0, last on the ninth); the ninth reply byte or a timeout
//   yields one reading (kind 1) with status and ppm.
//   The accepting edge loads the result descriptor; the sequencer then
//   copies it into its output register when free, raising out_valid.
//   Throughput: one request per cycle while in_ready is high; a start holds
//   the output for nine command bytes, and one descriptor may wait behind it.
//   Requests that cause no result (bytes mid-frame, ticks) keep flowing even
//   while the output is stalled; in_ready drops only while the descriptor
//   slot holds a result that the output has not taken.
//   Reset clears the exchange (idle), empties both stages and loads
//   timeout_ticks = 8000000 and max_ppm = 5000. Write cfg_* only while idle.
//   A stalled receiver holds out_* unchanged until out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module co2_sensor_frame_exchange_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [7:0]       tx_byte,
  output logic [2:0]       status,
  output logic [15:0]      ppm,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);

  // Descriptor handoff between the frame tracker and the beat sequencer
  logic             desc_valid;
  logic             desc_take;
  co2fx_pkg::desc_t desc;

  // Track the reply frame and timeout; load one descriptor per result
  co2fx_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .rx_byte    (rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take)
  );

  // Expand descriptors into output beats; hold while the receiver stalls
  co2fx_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .tx_byte    (tx_byte),
    .status     (status),
    .ppm        (ppm),
    .last       (last)
  );

endmodule

`default_nettype wire
